>>> hdl/gbn_pkg.sv
// Shared types, codes and constants of the Go-Back-N sender window.
package gbn_pkg;

  localparam int SEQ_W      = 16;
  localparam int PAY_W      = 64;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 2;
  localparam int CFG_W      = 4;
  localparam int WINDOW_DEF = 8;

  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(4);
  localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FN_SEND    = 2'd0,
    FN_ACK     = 2'd1,
    FN_TIMEOUT = 2'd2,
    FN_RSVD    = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    K_STATUS = 2'd0,
    K_TX     = 2'd1,
    K_START  = 2'd2,
    K_STOP   = 2'd3
  } kind_t;

  typedef struct packed {
    logic apply;
    logic emit_a;
    logic emit_b;
    logic rd;
    logic emit_tx;
  } cmd_t;

  typedef struct packed {
    logic has_b;
    logic walk;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/gbn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/gbn_ctrl.sv
// Sequencing state machine of the Go-Back-N sender window.
module gbn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gbn_pkg::sts_t sts,
  output gbn_pkg::cmd_t cmd
);

  import gbn_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EMIT_A = 6'b000010,
    ST_EMIT_B = 6'b000100,
    ST_RD     = 6'b001000,
    ST_TX     = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.apply = 1'b1;
          state_nxt = ST_EMIT_A;
        end
      end
      ST_EMIT_A: begin
        if (sts.out_free) begin
          cmd.emit_a = 1'b1;
          if (sts.has_b) begin
            state_nxt = ST_EMIT_B;
          end else if (sts.walk) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_B: begin
        if (sts.out_free) begin
          cmd.emit_b = 1'b1;
          state_nxt  = sts.walk ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_TX;
      end
      ST_TX: begin
        if (sts.out_free) begin
          cmd.emit_tx = 1'b1;
          state_nxt   = sts.walk_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/gbn_dp.sv
// Window state, payload ring, result planning and output register.
module gbn_dp #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gbn_pkg::cmd_t               cmd,
  output gbn_pkg::sts_t               sts,
  input  logic                        cfg_we,
  input  logic [gbn_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [gbn_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbn_pkg::PAY_W-1:0]   in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]   in_ack_num,
  input  logic                        in_ack_checksum_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbn_pkg::KIND_W-1:0]  out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]   out_seq_num,
  output logic [gbn_pkg::PAY_W-1:0]   out_packet_payload,
  output logic                        out_accepted,
  output logic                        out_window_full,
  output logic                        out_last
);

  import gbn_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] h,
                                                input logic [CNT_W-1:0] x);
    logic [SUM_W-1:0] sum;
    sum = {{(SUM_W-IDX_W){1'b0}}, h} + {1'b0, x};
    if (sum >= SUM_W'(WINDOW)) begin
      sum = sum - SUM_W'(WINDOW);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [CFG_W-1:0] len_r;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0] flight_r, flight_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] idx_r;

  kind_t            a_kind_r, a_kind_nxt, b_kind_r, b_kind_nxt;
  logic [SEQ_W-1:0] a_seq_r, a_seq_nxt, b_seq_r, b_seq_nxt;
  logic [PAY_W-1:0] pay_r;
  logic             acc_r, acc_nxt;
  logic             has_b_r, has_b_nxt;
  logic             walk_r, walk_nxt;

  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [SEQ_W-1:0] out_seq_r;
  logic [PAY_W-1:0] out_pay_r;
  logic             out_acc_r, out_full_r, out_last_r;

  logic [CMP_W-1:0] eff_len, flight_c;
  logic             room, full;
  logic [SEQ_W-1:0] ack_dist;
  logic             ack_ok;
  logic [CNT_W-1:0] slide;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [PAY_W-1:0] ram_rdata;
  logic             emit;
  logic [CNT_W-1:0] idx_inc;

  assign flight_c = CMP_W'(flight_r);
  assign eff_len  = (CMP_W'(len_r) < CMP_W'(WINDOW)) ? CMP_W'(len_r) : CMP_W'(WINDOW);
  assign room     = flight_c < eff_len;
  assign full     = flight_c >= eff_len;
  assign ack_dist = in_ack_num - base_r;
  assign ack_ok   = (flight_r != '0) && in_ack_checksum_ok &&
                    (ack_dist < {{(SEQ_W-CNT_W){1'b0}}, flight_r});
  assign slide    = ack_dist[CNT_W-1:0] + CNT_W'(1);
  assign idx_inc  = idx_r + CNT_W'(1);

  always_comb begin
    base_nxt   = base_r;
    next_nxt   = next_r;
    flight_nxt = flight_r;
    head_nxt   = head_r;
    a_kind_nxt = K_STATUS;
    a_seq_nxt  = base_r;
    b_kind_nxt = K_STATUS;
    b_seq_nxt  = base_r;
    acc_nxt    = 1'b0;
    has_b_nxt  = 1'b0;
    walk_nxt   = 1'b0;
    ram_we     = 1'b0;
    case (func_t'(in_func))
      FN_SEND: begin
        if (room) begin
          ram_we     = cmd.apply;
          acc_nxt    = 1'b1;
          has_b_nxt  = (flight_r == '0);
          a_kind_nxt = (flight_r == '0) ? K_START : K_TX;
          a_seq_nxt  = next_r;
          b_kind_nxt = K_TX;
          b_seq_nxt  = next_r;
          flight_nxt = flight_r + CNT_W'(1);
          next_nxt   = next_r + SEQ_W'(1);
        end
      end
      FN_ACK: begin
        if (ack_ok) begin
          acc_nxt    = 1'b1;
          a_kind_nxt = K_STOP;
          base_nxt   = in_ack_num + SEQ_W'(1);
          flight_nxt = flight_r - slide;
          head_nxt   = wrap_add(head_r, slide);
          has_b_nxt  = (flight_nxt != '0);
          b_kind_nxt = K_START;
          b_seq_nxt  = base_nxt;
        end
      end
      FN_TIMEOUT: begin
        if (flight_r != '0) begin
          a_kind_nxt = K_STOP;
          b_kind_nxt = K_START;
          has_b_nxt  = 1'b1;
          walk_nxt   = 1'b1;
        end
      end
      FN_RSVD: begin
        a_kind_nxt = K_STATUS;
      end
      default: begin
        a_kind_nxt = K_STATUS;
      end
    endcase
  end

  assign ram_waddr = wrap_add(head_r, flight_r);
  assign ram_raddr = wrap_add(head_r, idx_r);

  gbn_ram #(
    .WIDTH (PAY_W),
    .DEPTH (WINDOW),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_payload),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= LEN_RESET;
      base_r   <= SEQ_RESET;
      next_r   <= SEQ_RESET;
      flight_r <= '0;
      head_r   <= '0;
      has_b_r  <= 1'b0;
      walk_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      if (cmd.apply) begin
        base_r   <= base_nxt;
        next_r   <= next_nxt;
        flight_r <= flight_nxt;
        head_r   <= head_nxt;
        has_b_r  <= has_b_nxt;
        walk_r   <= walk_nxt;
        idx_r    <= '0;
      end else if (cmd.emit_tx) begin
        idx_r <= idx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      a_kind_r <= a_kind_nxt;
      a_seq_r  <= a_seq_nxt;
      b_kind_r <= b_kind_nxt;
      b_seq_r  <= b_seq_nxt;
      acc_r    <= acc_nxt;
      pay_r    <= in_payload;
    end
  end

  assign emit = cmd.emit_a || cmd.emit_b || cmd.emit_tx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_acc_r  <= acc_r;
      out_full_r <= full;
      if (cmd.emit_a) begin
        out_kind_r <= a_kind_r;
        out_seq_r  <= a_seq_r;
        out_pay_r  <= (a_kind_r == K_TX) ? pay_r : '0;
        out_last_r <= !has_b_r && !walk_r;
      end else if (cmd.emit_b) begin
        out_kind_r <= b_kind_r;
        out_seq_r  <= b_seq_r;
        out_pay_r  <= (b_kind_r == K_TX) ? pay_r : '0;
        out_last_r <= !walk_r;
      end else begin
        out_kind_r <= K_TX;
        out_seq_r  <= base_r + SEQ_W'(idx_r);
        out_pay_r  <= ram_rdata;
        out_last_r <= (idx_inc == flight_r);
      end
    end
  end

  assign sts.has_b     = has_b_r;
  assign sts.walk      = walk_r;
  assign sts.walk_last = (idx_inc == flight_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_seq_num        = out_seq_r;
  assign out_packet_payload = out_pay_r;
  assign out_accepted       = out_acc_r;
  assign out_window_full    = out_full_r;
  assign out_last           = out_last_r;

endmodule

>>> hdl/go_back_n_sender_window_unit.sv
// Top level of the Go-Back-N sender window.
//
// The input channel takes one event per beat: a send with a payload word, an
// ack with its number and checksum flag, or a timer expiry. The result channel
// gives one beat per result, and the last beat of an event carries out_last.
// The window length register is written through cfg_we and cfg_wdata; the
// user must do so only while the block is idle, as the block leaves it unchecked.
// An event is taken while the block is idle, and the results of a send or an
// ack then leave one per cycle while the receiver takes them. A timeout walks
// the payload ring, which has one registered read port: after its stop and
// start beats it reads and then sends each packet in flight in turn.
// The next event is taken once the last result of the current one has been
// loaded into the output register, even while that beat still waits.
// While a result waits to be loaded, the sequencer holds and in_ready is low.
// Reset sets the window base and next sequence number to 1, empties the
// window and sets the window length to 4. The payload ring is not cleared.
module go_back_n_sender_window_unit #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [gbn_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gbn_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbn_pkg::PAY_W-1:0]   in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]   in_ack_num,
  input  logic                        in_ack_checksum_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbn_pkg::KIND_W-1:0]  out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]   out_seq_num,
  output logic [gbn_pkg::PAY_W-1:0]   out_packet_payload,
  output logic                        out_accepted,
  output logic                        out_window_full,
  output logic                        out_last
);

  import gbn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_func            (in_func),
    .in_payload         (in_payload),
    .in_ack_num         (in_ack_num),
    .in_ack_checksum_ok (in_ack_checksum_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_seq_num        (out_seq_num),
    .out_packet_payload (out_packet_payload),
    .out_accepted       (out_accepted),
    .out_window_full    (out_window_full),
    .out_last           (out_last)
  );

endmodule

>>> hdl/gbn_chk.sv
// Port-level checker of the Go-Back-N sender window and its bind statement.
module gbn_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gbn_pkg::KIND_W-1:0]  out_kind,
  input logic [gbn_pkg::SEQ_W-1:0]   out_seq_num,
  input logic [gbn_pkg::PAY_W-1:0]   out_packet_payload,
  input logic                        out_accepted,
  input logic                        out_last
);

  import gbn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_seq_num) && $stable(out_packet_payload))
    else $error("Stalled result beat changed.");

  a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != K_TX) |-> out_packet_payload == '0)
    else $error("Non-transmit beat carries a payload.");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_STATUS) |-> out_last)
    else $error("Status beat is not the last of its event.");

  a_status_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_STATUS) |-> !out_accepted)
    else $error("Status beat is marked accepted.");

endmodule

bind go_back_n_sender_window_unit gbn_chk u_gbn_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kind           (out_kind),
  .out_seq_num        (out_seq_num),
  .out_packet_payload (out_packet_payload),
  .out_accepted       (out_accepted),
  .out_last           (out_last)
);
